[rtl/core/ledpg_pkg.sv]
// ledpg_pkg: types and constants for the led pattern generator
// no dependencies; used by led_pattern_generator

package ledpg_pkg;

    // pattern codes
    localparam logic [2:0] PAT_OFF   = 3'd0;
    localparam logic [2:0] PAT_SOLID = 3'd1;
    localparam logic [2:0] PAT_SLOW  = 3'd2;
    localparam logic [2:0] PAT_FAST  = 3'd3;
    localparam logic [2:0] PAT_FLASH = 3'd4;
    localparam logic [2:0] PAT_PULSE = 3'd5;

    // item kinds
    localparam logic KIND_TICK   = 1'b0;
    localparam logic KIND_SELECT = 1'b1;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_HALF  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_HALF  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_LEN  = 2'd3;

    // configuration reset values
    localparam logic [CFG_DATA_W-1:0] SLOW_HALF_RST = 16'd500;
    localparam logic [CFG_DATA_W-1:0] FAST_HALF_RST = 16'd125;
    localparam logic [CFG_DATA_W-1:0] FLASH_LEN_RST = 16'd200;

    // pulse ramp: 2000 ms triangle, 100 ms windows, duty = phase / 10
    localparam int unsigned PHASE_W = 11;
    localparam logic [PHASE_W-1:0] PULSE_PERIOD = 11'd2000;
    localparam logic [PHASE_W-1:0] PULSE_LAST   = 11'd1999;
    localparam logic [PHASE_W-1:0] PULSE_HALF   = 11'd1000;
    localparam int unsigned FOLD_W = 10;
    localparam int unsigned ON_W = 7;
    localparam logic [ON_W-1:0] PULSE_WINDOW = 7'd100;
    // x / 10 == (x * 205) >> 11 for x up to 1028
    localparam int unsigned DIV10_MUL_W = 18;
    localparam logic [DIV10_MUL_W-1:0] DIV10_RECIP = 18'd205;
    localparam int unsigned DIV10_SHIFT = 11;

    typedef struct packed {
        logic       kind;
        logic [2:0] pattern_code;
    } t_in_item;

    typedef struct packed {
        logic       led_on;
        logic       pin_level;
        logic [2:0] active_pattern;
    } t_out_item;

endpackage

[rtl/core/led_pattern_generator.sv]
// led_pattern_generator: pattern state, timers and result register
// depends on ledpg_pkg for item types, pattern codes and constants
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) carries one item per
//   transaction: a one-millisecond tick or a pattern selection. Output channel
//   (o_out_valid / i_out_stall / o_out_item) returns exactly one result per
//   input item, in order: led state, pin level and pattern in force.
//   Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while
//   no item is in flight; writes take effect at the next clock edge.
//   Result valid rises once the input register has taken the item and an
//   edge that no receiver stall holds off loads the state update into the
//   result register. Throughput is one item per cycle while the receiver
//   does not stall; the combinational state update sets that rate.
//   When the receiver stalls, the result register holds and the input
//   register fills; the input side stalls only once both are occupied.
//   Synchronous active-low reset clears both valid flags, the pattern (off),
//   the led, timers and pulse phase, and loads the default configuration.

module led_pattern_generator #(
    parameter int unsigned TIMER_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  ledpg_pkg::t_in_item                 i_in_item,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output ledpg_pkg::t_out_item                o_out_item,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [ledpg_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ledpg_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    // compare width covering both timers and interval registers
    localparam int unsigned CMP_W =
        (TIMER_WIDTH > ledpg_pkg::CFG_DATA_W) ? TIMER_WIDTH : ledpg_pkg::CFG_DATA_W;

    // configuration registers
    logic                               r_active_low;
    logic [ledpg_pkg::CFG_DATA_W-1:0]   r_slow_half;
    logic [ledpg_pkg::CFG_DATA_W-1:0]   r_fast_half;
    logic [ledpg_pkg::CFG_DATA_W-1:0]   r_flash_len;

    // pipeline registers
    logic                   r_in_vld;
    ledpg_pkg::t_in_item    r_in;
    logic                   r_out_vld;
    ledpg_pkg::t_out_item   r_out;

    // pattern state
    logic [2:0]                     r_pattern, n_pattern;
    logic                           r_lit, n_lit;
    logic [TIMER_WIDTH-1:0]         r_since_start, n_since_start;
    logic [TIMER_WIDTH-1:0]         r_since_toggle, n_since_toggle;
    logic [ledpg_pkg::PHASE_W-1:0]  r_phase, n_phase;

    // tick intermediates
    logic                               proc_fire;
    logic [TIMER_WIDTH-1:0]             start_inc;
    logic [TIMER_WIDTH-1:0]             toggle_inc;
    logic [ledpg_pkg::PHASE_W-1:0]      phase_inc;
    logic [ledpg_pkg::FOLD_W-1:0]       phase_fold;
    logic [ledpg_pkg::DIV10_MUL_W-1:0]  div_prod;
    logic [ledpg_pkg::ON_W-1:0]         on_time;
    logic [ledpg_pkg::ON_W-1:0]         off_time;
    logic                               slow_due;
    logic                               fast_due;
    logic                               flash_due;
    logic                               on_due;
    logic                               off_due;

    // handshake: process when the result slot is free or draining
    assign proc_fire   = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall  = r_in_vld && !proc_fire;
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    // saturating timers and wrapping pulse phase
    assign start_inc  = (r_since_start == '1) ? r_since_start : r_since_start + 1'b1;
    assign toggle_inc = (r_since_toggle == '1) ? r_since_toggle : r_since_toggle + 1'b1;
    assign phase_inc  = (r_phase == ledpg_pkg::PULSE_LAST) ? '0 : r_phase + 1'b1;

    // pulse on time: folded phase divided by ten through a reciprocal multiply
    assign phase_fold = (phase_inc < ledpg_pkg::PULSE_HALF)
                        ? ledpg_pkg::FOLD_W'(phase_inc)
                        : ledpg_pkg::FOLD_W'(ledpg_pkg::PULSE_PERIOD - phase_inc);
    assign div_prod   = ledpg_pkg::DIV10_MUL_W'(phase_fold) * ledpg_pkg::DIV10_RECIP;
    assign on_time    = div_prod[ledpg_pkg::DIV10_SHIFT +: ledpg_pkg::ON_W];
    assign off_time   = ledpg_pkg::PULSE_WINDOW - on_time;

    // elapsed-time compares on the advanced timers
    assign slow_due  = CMP_W'(toggle_inc) >= CMP_W'(r_slow_half);
    assign fast_due  = CMP_W'(toggle_inc) >= CMP_W'(r_fast_half);
    assign flash_due = CMP_W'(start_inc) >= CMP_W'(r_flash_len);
    assign on_due    = toggle_inc >= TIMER_WIDTH'(on_time);
    assign off_due   = toggle_inc >= TIMER_WIDTH'(off_time);

    // next state for one item
    always_comb begin
        n_pattern      = r_pattern;
        n_lit          = r_lit;
        n_since_start  = r_since_start;
        n_since_toggle = r_since_toggle;
        n_phase        = r_phase;
        if (r_in.kind == ledpg_pkg::KIND_TICK) begin
            n_since_start  = start_inc;
            n_since_toggle = toggle_inc;
            n_phase        = phase_inc;
            unique case (r_pattern)
                ledpg_pkg::PAT_SLOW: begin
                    if (slow_due) begin
                        n_since_toggle = '0;
                        n_lit          = !r_lit;
                    end
                end
                ledpg_pkg::PAT_FAST: begin
                    if (fast_due) begin
                        n_since_toggle = '0;
                        n_lit          = !r_lit;
                    end
                end
                ledpg_pkg::PAT_FLASH: begin
                    if (flash_due) begin
                        n_lit     = 1'b0;
                        n_pattern = ledpg_pkg::PAT_OFF;
                    end
                end
                ledpg_pkg::PAT_PULSE: begin
                    if (r_lit && on_due) begin
                        n_lit          = 1'b0;
                        n_since_toggle = '0;
                    end else if (!r_lit && off_due) begin
                        n_lit          = 1'b1;
                        n_since_toggle = '0;
                    end
                end
                default: begin
                end
            endcase
        end else if (r_in.pattern_code <= ledpg_pkg::PAT_PULSE &&
                     r_in.pattern_code != r_pattern) begin
            // new pattern restarts timers
            n_pattern      = r_in.pattern_code;
            n_since_start  = '0;
            n_since_toggle = '0;
            n_phase        = '0;
            if (r_in.pattern_code == ledpg_pkg::PAT_OFF) begin
                n_lit = 1'b0;
            end else if (r_in.pattern_code == ledpg_pkg::PAT_SOLID ||
                         r_in.pattern_code == ledpg_pkg::PAT_FLASH) begin
                n_lit = 1'b1;
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_low <= 1'b0;
            r_slow_half  <= ledpg_pkg::SLOW_HALF_RST;
            r_fast_half  <= ledpg_pkg::FAST_HALF_RST;
            r_flash_len  <= ledpg_pkg::FLASH_LEN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ledpg_pkg::CFG_ACTIVE_LOW: r_active_low <= i_cfg_data[0];
                ledpg_pkg::CFG_SLOW_HALF:  r_slow_half  <= i_cfg_data;
                ledpg_pkg::CFG_FAST_HALF:  r_fast_half  <= i_cfg_data;
                ledpg_pkg::CFG_FLASH_LEN:  r_flash_len  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_item;
        end
    end

    // pattern state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern      <= ledpg_pkg::PAT_OFF;
            r_lit          <= 1'b0;
            r_since_start  <= '0;
            r_since_toggle <= '0;
            r_phase        <= '0;
        end else if (proc_fire) begin
            r_pattern      <= n_pattern;
            r_lit          <= n_lit;
            r_since_start  <= n_since_start;
            r_since_toggle <= n_since_toggle;
            r_phase        <= n_phase;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (proc_fire) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire) begin
            r_out.led_on         <= n_lit;
            r_out.pin_level      <= n_lit ^ r_active_low;
            r_out.active_pattern <= n_pattern;
        end
    end

endmodule

[verif/led_pattern_generator_check.sv]
`timescale 1ns / 100ps
// led_pattern_generator_check: watches the item, result and register ports,
// predicts each result and compares it field by field; depends on ledpg_pkg

module led_pattern_generator_check #(
    parameter int unsigned TIMER_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  ledpg_pkg::t_in_item                 i_in_item,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  ledpg_pkg::t_out_item                i_out_item,
    input  logic                                i_cfg_we,
    input  logic [ledpg_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ledpg_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output int unsigned                         o_outstanding,
    output int unsigned                         o_fail_count
);
    import ledpg_pkg::*;

    localparam int unsigned DUTY_DIV = 10;

    // predicted register copies
    logic                  active_low;
    logic [CFG_DATA_W-1:0] slow_ms;
    logic [CFG_DATA_W-1:0] fast_ms;
    logic [CFG_DATA_W-1:0] flash_ms;

    // predicted pattern state
    logic [2:0]             pattern;
    logic                   lit;
    logic [TIMER_WIDTH-1:0] ms_since_start;
    logic [TIMER_WIDTH-1:0] ms_since_toggle;
    logic [PHASE_W-1:0]     ramp_phase;

    t_out_item   expected_led_q[$];
    int unsigned fails = 0;

    // apply one transaction to the predicted state and return the led result
    function automatic t_out_item step_led(input t_in_item item);
        t_out_item   res;
        int unsigned on_ms;
        if (item.kind == KIND_TICK) begin
            if (ms_since_start != '1) ms_since_start = ms_since_start + 1'b1;
            if (ms_since_toggle != '1) ms_since_toggle = ms_since_toggle + 1'b1;
            ramp_phase = (ramp_phase >= PULSE_LAST) ? '0 : ramp_phase + 1'b1;
            case (pattern)
                PAT_SLOW: begin
                    if (ms_since_toggle >= slow_ms) begin
                        ms_since_toggle = '0;
                        lit = ~lit;
                    end
                end
                PAT_FAST: begin
                    if (ms_since_toggle >= fast_ms) begin
                        ms_since_toggle = '0;
                        lit = ~lit;
                    end
                end
                PAT_FLASH: begin
                    if (ms_since_start >= flash_ms) begin
                        lit = 1'b0;
                        pattern = PAT_OFF;
                    end
                end
                PAT_PULSE: begin
                    // triangle duty: on time rises to the full window, then falls
                    on_ms = (ramp_phase < PULSE_HALF) ? ramp_phase / DUTY_DIV
                          : (PULSE_PERIOD - ramp_phase) / DUTY_DIV;
                    if (lit && ms_since_toggle >= on_ms) begin
                        lit = 1'b0;
                        ms_since_toggle = '0;
                    end else if (!lit && ms_since_toggle >= PULSE_WINDOW - on_ms) begin
                        lit = 1'b1;
                        ms_since_toggle = '0;
                    end
                end
                default: ;
            endcase
        end else if (item.pattern_code <= PAT_PULSE && item.pattern_code != pattern) begin
            // a new pattern restarts both timers and the ramp
            pattern = item.pattern_code;
            ms_since_start = '0;
            ms_since_toggle = '0;
            ramp_phase = '0;
            if (pattern == PAT_OFF) lit = 1'b0;
            else if (pattern == PAT_SOLID || pattern == PAT_FLASH) lit = 1'b1;
        end
        res.led_on = lit;
        res.pin_level = lit ^ active_low;
        res.active_pattern = pattern;
        return res;
    endfunction

    // track registers, predict on each input transaction, check each result
    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            active_low = 1'b0;
            slow_ms = SLOW_HALF_RST;
            fast_ms = FAST_HALF_RST;
            flash_ms = FLASH_LEN_RST;
            pattern = PAT_OFF;
            lit = 1'b0;
            ms_since_start = '0;
            ms_since_toggle = '0;
            ramp_phase = '0;
            expected_led_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ACTIVE_LOW: active_low = i_cfg_data[0];
                    CFG_SLOW_HALF:  slow_ms = i_cfg_data;
                    CFG_FAST_HALF:  fast_ms = i_cfg_data;
                    CFG_FLASH_LEN:  flash_ms = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) expected_led_q.push_back(step_led(i_in_item));
            if (i_out_valid && !i_out_stall) begin
                if (expected_led_q.size() == 0) begin
                    $error("result with no transaction outstanding: led_on %0b pin %0b pattern %0d",
                           i_out_item.led_on, i_out_item.pin_level, i_out_item.active_pattern);
                    fails++;
                end else begin
                    want = expected_led_q.pop_front();
                    if (i_out_item.led_on !== want.led_on) begin
                        $error("led_on: expected %0b, got %0b", want.led_on, i_out_item.led_on);
                        fails++;
                    end
                    if (i_out_item.pin_level !== want.pin_level) begin
                        $error("pin_level: expected %0b, got %0b",
                               want.pin_level, i_out_item.pin_level);
                        fails++;
                    end
                    if (i_out_item.active_pattern !== want.active_pattern) begin
                        $error("active_pattern: expected %0d, got %0d",
                               want.active_pattern, i_out_item.active_pattern);
                        fails++;
                    end
                end
            end
        end
        o_outstanding <= expected_led_q.size();
        o_fail_count <= fails;
    end

endmodule

[verif/led_pattern_generator_test.sv]
`timescale 1ns / 100ps
// led_pattern_generator_test: clock, reset, stimulus and verdict for the led
// pattern generator; depends on ledpg_pkg and led_pattern_generator_check

module led_pattern_generator_test;

    localparam int unsigned TIMER_W = 16;
    // codes outside the defined patterns
    localparam logic [2:0] PAT_BAD_LO = 3'd6;
    localparam logic [2:0] PAT_BAD_HI = 3'd7;
    localparam logic [ledpg_pkg::CFG_DATA_W-1:0] INTERVAL_MAX = '1;

    logic                                  clk = 1'b0;
    logic                                  rst_n = 1'b0;
    logic                                  in_valid = 1'b0;
    logic                                  in_stall;
    ledpg_pkg::t_in_item                   in_item = '0;
    logic                                  out_valid;
    logic                                  out_stall = 1'b0;
    ledpg_pkg::t_out_item                  out_item;
    logic                                  cfg_we = 1'b0;
    logic [ledpg_pkg::CFG_IDX_W-1:0]       cfg_idx = ledpg_pkg::CFG_ACTIVE_LOW;
    logic [ledpg_pkg::CFG_DATA_W-1:0]      cfg_data = '0;
    logic                                  steady = 1'b0;
    int unsigned                           outstanding;
    int unsigned                           fail_count;
    int unsigned                           stall_hold = 0;

    led_pattern_generator #(.TIMER_WIDTH(TIMER_W)) dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_item(in_item),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_item(out_item),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    led_pattern_generator_check #(.TIMER_WIDTH(TIMER_W)) checker_i (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_item(in_item),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_item(out_item),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_outstanding(outstanding), .o_fail_count(fail_count)
    );

    // 20 ns clock
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // idle length: mostly none, often short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (steady || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver stall: random runs of stalled and free cycles, none in reset or steady runs
    always @(posedge clk) begin
        if (!rst_n || steady) begin
            out_stall <= 1'b0;
            stall_hold = 0;
        end else if (stall_hold != 0) begin
            stall_hold--;
        end else if ($urandom_range(99) < 30) begin
            out_stall <= 1'b1;
            stall_hold = pick_gap();
        end else begin
            out_stall <= 1'b0;
            stall_hold = ($urandom_range(9) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 8);
        end
    end

    function automatic ledpg_pkg::t_in_item item_of(input logic kind,
                                                    input logic [2:0] code);
        ledpg_pkg::t_in_item it;
        it.kind = kind;
        it.pattern_code = code;
        return it;
    endfunction

    // one input transaction, returns at the edge that accepts it
    task automatic send_item(input ledpg_pkg::t_in_item item);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic select(input logic [2:0] code);
        send_item(item_of(ledpg_pkg::KIND_SELECT, code));
    endtask

    // ticks carry a random pattern code that the block must ignore
    task automatic tick_run(input int unsigned n);
        repeat (n) send_item(item_of(ledpg_pkg::KIND_TICK, 3'($urandom)));
    endtask

    // hold off the sender until every result has come back
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ledpg_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ledpg_pkg::CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic set_config(input logic al,
                              input logic [ledpg_pkg::CFG_DATA_W-1:0] slow,
                              input logic [ledpg_pkg::CFG_DATA_W-1:0] fast,
                              input logic [ledpg_pkg::CFG_DATA_W-1:0] flash);
        write_reg(ledpg_pkg::CFG_ACTIVE_LOW, ledpg_pkg::CFG_DATA_W'(al));
        write_reg(ledpg_pkg::CFG_SLOW_HALF, slow);
        write_reg(ledpg_pkg::CFG_FAST_HALF, fast);
        write_reg(ledpg_pkg::CFG_FLASH_LEN, flash);
        cfg_we <= 1'b0;
    endtask

    // interval register value: mostly short so patterns move within a round
    function automatic logic [ledpg_pkg::CFG_DATA_W-1:0] pick_interval();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70) return ledpg_pkg::CFG_DATA_W'($urandom_range(0, 12));
        if (r < 90) return ledpg_pkg::CFG_DATA_W'($urandom_range(13, 300));
        return ledpg_pkg::CFG_DATA_W'($urandom);
    endfunction

    // random transaction: mostly ticks, some selections, a few bad codes
    function automatic ledpg_pkg::t_in_item random_item();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 18) begin
            return item_of(ledpg_pkg::KIND_SELECT,
                           3'($urandom_range(ledpg_pkg::PAT_OFF, ledpg_pkg::PAT_PULSE)));
        end
        if (r < 20) begin
            return item_of(ledpg_pkg::KIND_SELECT,
                           3'($urandom_range(PAT_BAD_LO, PAT_BAD_HI)));
        end
        return item_of(ledpg_pkg::KIND_TICK, 3'($urandom));
    endfunction

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset configuration: every pattern, repeats, bad codes
        send_item(item_of(ledpg_pkg::KIND_TICK, PAT_BAD_HI));
        select(ledpg_pkg::PAT_OFF);
        select(ledpg_pkg::PAT_SOLID);
        send_item(item_of(ledpg_pkg::KIND_TICK, ledpg_pkg::PAT_PULSE));
        select(ledpg_pkg::PAT_SOLID);
        select(PAT_BAD_LO);
        select(PAT_BAD_HI);
        select(ledpg_pkg::PAT_SLOW);
        tick_run(1);
        select(ledpg_pkg::PAT_FAST);
        tick_run(1);
        select(ledpg_pkg::PAT_FLASH);
        tick_run(1);
        select(ledpg_pkg::PAT_PULSE);
        tick_run(2);
        select(ledpg_pkg::PAT_OFF);
        send_item(item_of(ledpg_pkg::KIND_TICK, ledpg_pkg::PAT_SOLID));

        // zero intervals with the pin inverted
        settle();
        set_config(1'b1, '0, '0, '0);
        select(ledpg_pkg::PAT_SLOW);
        tick_run(3);
        select(ledpg_pkg::PAT_FAST);
        tick_run(2);
        select(ledpg_pkg::PAT_FLASH);
        tick_run(2);
        select(ledpg_pkg::PAT_SOLID);
        select(ledpg_pkg::PAT_OFF);

        // back to back runs: pulse windows, blink toggles and flash end
        settle();
        steady <= 1'b1;
        set_config(1'b0, 16'd20, 16'd6, 16'd20);
        select(ledpg_pkg::PAT_PULSE);
        tick_run(120);
        select(ledpg_pkg::PAT_SLOW);
        tick_run(50);
        select(ledpg_pkg::PAT_FAST);
        tick_run(20);
        select(ledpg_pkg::PAT_FLASH);
        tick_run(25);

        // largest intervals: patterns hold
        settle();
        set_config(1'b1, INTERVAL_MAX, INTERVAL_MAX, INTERVAL_MAX);
        select(ledpg_pkg::PAT_FLASH);
        tick_run(10);
        select(ledpg_pkg::PAT_SLOW);
        tick_run(10);
        settle();
        steady <= 1'b0;

        // random rounds, each under a fresh random configuration
        for (int round = 0; round < 6; round++) begin
            settle();
            steady <= ($urandom_range(3) == 0);
            set_config(1'($urandom), pick_interval(), pick_interval(), pick_interval());
            repeat (22) send_item(random_item());
        end

        settle();
        repeat (4) @(posedge clk);
        if (fail_count == 0) begin
            $display("led_pattern_generator_test: done, clean");
        end else begin
            $display("led_pattern_generator_test: done, errors");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("led_pattern_generator_test: done, errors");
        $finish;
    end

endmodule

[sim.f]
rtl/core/ledpg_pkg.sv
rtl/core/led_pattern_generator.sv
verif/led_pattern_generator_check.sv
verif/led_pattern_generator_test.sv
